@@ hdl/bfpd_pkg.sv @@
// Shared op codes, status codes, transaction types and sequencer states for the byte FIFO.
`default_nettype none
package bfpd_pkg;

  localparam logic [2:0] OP_PUSH       = 3'd0;
  localparam logic [2:0] OP_PUSH_BURST = 3'd1;
  localparam logic [2:0] OP_POP        = 3'd2;
  localparam logic [2:0] OP_POP_BURST  = 3'd3;
  localparam logic [2:0] OP_PEEK       = 3'd4;
  localparam logic [2:0] OP_FLUSH      = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_UNDERRUN = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;
  localparam logic [2:0] ST_DROPPED  = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] byte_in;
    logic [7:0] length;
    logic       do_ensure;
  } in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [8:0] fill_level;
    logic [2:0] status;
    logic       burst_done;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_ENS_CHK,
    S_ENS_RD,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

@@ hdl/bfpd_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none
module bfpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ hdl/byte_fifo_packet_drop.sv @@
// Top level: byte ring-buffer FIFO with burst checks and packet-drop ensure.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+---------------------
//  in_     | in  | in_valid / in_stall | bfpd_pkg::in_t
//  out_    | out | out_valid/out_stall | bfpd_pkg::out_t
//
// Sequencing: one transaction at a time. Push, burst push, flush, reject,
//   unused ops and every item that reads no byte (empty pop or peek,
//   dropped or underrun burst pop) go from execute to finish; a pop, peek
//   or burst pop that reads the store adds a read step (the store read is
//   registered). Ensure adds a check and a length-byte read per dropped
//   head packet, as the single store read port walks the length bytes.
// Reset: rst_n synchronous, active low; pointers, occupancy and burst state go
//   to zero. The store is not cleared; only written entries are ever read.
// Stalls: a finished result waits in the output register while the next input
//   transaction is accepted; out_stall only holds the block at result hand-off.
`default_nettype none
module byte_fifo_packet_drop #(
  parameter int DEPTH = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire bfpd_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output bfpd_pkg::out_t      out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  // compare width: covers occupancy, 8-bit lengths and the fill-level field
  localparam int CW = ((OW > 8) ? OW : 8) + 1;
  localparam int PW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
  localparam logic [AW-1:0] LAST_P  = AW'(DEPTH - 1);

  bfpd_pkg::state_t state_r, state_nxt;
  bfpd_pkg::in_t    item_r, item_nxt;
  bfpd_pkg::out_t   out_data_r, out_data_nxt;

  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [7:0]    bl_r, bl_nxt;
  logic          disc_r, disc_nxt;
  logic          take_r, take_nxt;
  logic [7:0]    bout_r, bout_nxt;
  logic [2:0]    status_r, status_nxt;
  logic          done_r, done_nxt;
  logic          out_valid_r, out_valid_nxt;

  // store port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;

  // shared arithmetic
  logic [CW-1:0] occ_c;
  logic [CW-1:0] len_c;
  logic [CW-1:0] n_c;
  logic [CW-1:0] skip_c;
  logic [PW-1:0] rp_sum;
  logic [AW-1:0] rp_inc;
  logic [AW-1:0] wp_inc;
  logic [7:0]    n8;
  logic [7:0]    bl_work;
  logic          disc_work;
  logic          push_b;
  logic          full;
  logic          empty;

  bfpd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (item_r.byte_in),
    .rdata (ram_rdata)
  );

  assign occ_c   = CW'(occ_r);
  assign len_c   = CW'(item_r.length);
  assign n8      = (item_r.length == 8'd0) ? 8'd1 : item_r.length;
  assign n_c     = CW'(n8);
  assign skip_c  = CW'(ram_rdata);
  assign full    = (occ_c >= DEPTH_C);
  assign empty   = (occ_r == '0);
  assign push_b  = (item_r.op == bfpd_pkg::OP_PUSH_BURST);
  assign rp_inc  = (rp_r == LAST_P) ? '0 : rp_r + AW'(1);
  assign wp_inc  = (wp_r == LAST_P) ? '0 : wp_r + AW'(1);
  // head after dropping the length byte and the packet it announces
  assign rp_sum  = PW'(rp_r) + PW'(1) + PW'(ram_rdata);

  assign in_stall  = (state_r != bfpd_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    rp_nxt        = rp_r;
    wp_nxt        = wp_r;
    occ_nxt       = occ_r;
    bl_nxt        = bl_r;
    disc_nxt      = disc_r;
    take_nxt      = take_r;
    bout_nxt      = bout_r;
    status_nxt    = status_r;
    done_nxt      = done_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;
    ram_we        = 1'b0;
    ram_addr      = rp_r;
    bl_work       = bl_r;
    disc_work     = disc_r;

    unique case (state_r)
      bfpd_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = bfpd_pkg::S_EXEC;
        end
      end

      bfpd_pkg::S_EXEC: begin
        bout_nxt   = 8'd0;
        status_nxt = bfpd_pkg::ST_OK;
        done_nxt   = 1'b0;
        take_nxt   = 1'b0;
        state_nxt  = bfpd_pkg::S_FIN;
        unique case (item_r.op)
          bfpd_pkg::OP_PUSH: begin
            if (full) begin
              rp_nxt     = '0;
              wp_nxt     = '0;
              occ_nxt    = '0;
              status_nxt = bfpd_pkg::ST_OVERFLOW;
            end else begin
              ram_we   = 1'b1;
              ram_addr = wp_r;
              wp_nxt   = wp_inc;
              occ_nxt  = occ_r + OW'(1);
            end
          end
          bfpd_pkg::OP_POP, bfpd_pkg::OP_PEEK: begin
            if (empty) begin
              status_nxt = bfpd_pkg::ST_EMPTY;
            end else begin
              take_nxt  = (item_r.op == bfpd_pkg::OP_POP);
              state_nxt = bfpd_pkg::S_RD;
            end
          end
          bfpd_pkg::OP_PUSH_BURST, bfpd_pkg::OP_POP_BURST: begin
            if (bl_r == 8'd0) begin
              // first item: check the whole burst
              bl_work   = n8;
              disc_work = 1'b0;
              if (push_b ? (occ_c + n_c > DEPTH_C) : (occ_c < n_c)) begin
                rp_nxt     = '0;
                wp_nxt     = '0;
                occ_nxt    = '0;
                disc_work  = 1'b1;
                status_nxt = push_b ? bfpd_pkg::ST_OVERFLOW : bfpd_pkg::ST_UNDERRUN;
              end
            end else if (disc_r) begin
              status_nxt = bfpd_pkg::ST_DROPPED;
            end else if (push_b ? full : empty) begin
              rp_nxt     = '0;
              wp_nxt     = '0;
              occ_nxt    = '0;
              disc_work  = 1'b1;
              status_nxt = push_b ? bfpd_pkg::ST_OVERFLOW : bfpd_pkg::ST_UNDERRUN;
            end
            if (!disc_work) begin
              if (push_b) begin
                ram_we   = 1'b1;
                ram_addr = wp_r;
                wp_nxt   = wp_inc;
                occ_nxt  = occ_r + OW'(1);
              end else begin
                take_nxt  = 1'b1;
                state_nxt = bfpd_pkg::S_RD;
              end
            end
            bl_work = bl_work - 8'd1;
            if (bl_work == 8'd0) begin
              done_nxt  = 1'b1;
              disc_work = 1'b0;
            end
            bl_nxt   = bl_work;
            disc_nxt = disc_work;
          end
          bfpd_pkg::OP_FLUSH: begin
            if (!item_r.do_ensure) begin
              rp_nxt  = '0;
              wp_nxt  = '0;
              occ_nxt = '0;
            end else if (len_c > DEPTH_C) begin
              status_nxt = bfpd_pkg::ST_REJECTED;
            end else begin
              state_nxt = bfpd_pkg::S_ENS_CHK;
            end
          end
          default: begin
          end
        endcase
      end

      bfpd_pkg::S_RD: begin
        bout_nxt = ram_rdata;
        if (take_r) begin
          rp_nxt  = rp_inc;
          occ_nxt = occ_r - OW'(1);
        end
        state_nxt = bfpd_pkg::S_FIN;
      end

      bfpd_pkg::S_ENS_CHK: begin
        // free space below request: fetch the next packet length byte
        if ((occ_c + len_c > DEPTH_C) && !empty) begin
          state_nxt = bfpd_pkg::S_ENS_RD;
        end else begin
          state_nxt = bfpd_pkg::S_FIN;
        end
      end

      bfpd_pkg::S_ENS_RD: begin
        if (skip_c >= occ_c) begin
          // announced packet longer than what is left
          rp_nxt  = '0;
          wp_nxt  = '0;
          occ_nxt = '0;
        end else begin
          rp_nxt  = AW'((rp_sum >= DEPTH_P) ? rp_sum - DEPTH_P : rp_sum);
          occ_nxt = OW'(occ_c - CW'(1) - skip_c);
        end
        state_nxt = bfpd_pkg::S_ENS_CHK;
      end

      bfpd_pkg::S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.byte_out   = bout_r;
          out_data_nxt.fill_level = occ_c[8:0];
          out_data_nxt.status     = status_r;
          out_data_nxt.burst_done = done_r;
          out_valid_nxt           = 1'b1;
          state_nxt               = bfpd_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bfpd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfpd_pkg::S_IDLE;
      rp_r        <= '0;
      wp_r        <= '0;
      occ_r       <= '0;
      bl_r        <= '0;
      disc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      wp_r        <= wp_nxt;
      occ_r       <= occ_nxt;
      bl_r        <= bl_nxt;
      disc_r      <= disc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    take_r     <= take_nxt;
    bout_r     <= bout_nxt;
    status_r   <= status_nxt;
    done_r     <= done_nxt;
    out_data_r <= out_data_nxt;
  end

  // occupancy never passes the store depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_c <= DEPTH_C)
    else $error("occupancy above depth");

  // a dropping burst always has items left
  a_disc_live: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (bl_r != 8'd0))
    else $error("burst discard without active burst");

  // a new result only comes out of the finish step
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(state_r == bfpd_pkg::S_FIN))
    else $error("result loaded outside finish step");

  // overflow and underrun results report an emptied FIFO
  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == bfpd_pkg::ST_OVERFLOW
                     || out_data_r.status == bfpd_pkg::ST_UNDERRUN))
    |-> (out_data_r.fill_level == 9'd0))
    else $error("flush status with nonzero fill level");

endmodule
`default_nettype wire
